/* rtl/psnfa_pkg.sv */
// Package for the next-fit slot allocator.
// Holds the payload structs, mode and command codes and the controller/datapath links.
// Depends on nothing.
package psnfa_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = 4;
	localparam int MAX_BURST = 64;
	localparam int BURST_W   = 7;
	localparam int LIVE_W    = 5;
	localparam int FRAME_W   = 16;
	localparam int TOTAL_W   = 32;

	localparam logic [1:0] MODE_EMIT    = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_FRAME   = 2'd3;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_STATUS = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
	localparam logic [OP_W-1:0] OP_GRANT  = 3'd3;
	localparam logic [OP_W-1:0] OP_REJECT = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [BURST_W-1:0] burst_count;
		logic [SLOT_W-1:0]  release_index;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_index;
		logic               granted;
		logic [BURST_W-1:0] rejected_now;
		logic [FRAME_W-1:0] emitted_in_frame;
		logic [TOTAL_W-1:0] rejected_sum;
		logic [LIVE_W-1:0]  live_count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic found;
		logic remaining_one;
		logic burst_zero;
	} stat_t;

endpackage

/* rtl/particle_slot_next_fit_allocator.sv */
// Top level of the next-fit slot allocator.
// Joins psnfa_ctrl and psnfa_datapath; uses psnfa_pkg.
//
// Sixteen slots are handed out next-fit from a rotating pointer, one item at a
// time. Release, clear, frame start and an empty burst each give one result. An
// emit burst of n requests is loaded first and then gives one result per grant.
// When the pool runs out, one closing result stands in place of the requests
// still open. The rotating search of the alive vector yields one grant per cycle
// while the output register can take it. Each result sits in an output register,
// and the block waits while that register is full and stalled.
module particle_slot_next_fit_allocator (
	input  logic               clk,
	input  logic               arst_n,
	input  psnfa_pkg::item_t   item,
	input  logic               item_valid,
	output logic               item_stall,
	output psnfa_pkg::result_t result,
	output logic               result_valid,
	input  logic               result_stall
);

	psnfa_pkg::cmd_t  cmd;
	psnfa_pkg::stat_t stat;

	psnfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_mode  (item.mode),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	psnfa_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.live_count <= psnfa_pkg::LIVE_W'(psnfa_pkg::SLOTS)))
		else $error("Live count exceeds the pool size.");

	a_grant_no_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.granted) |-> (result.rejected_now == '0))
		else $error("A granted result reports refused requests.");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.granted) |-> result.last)
		else $error("A result without a grant is not the final one of its item.");

	a_no_intake_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == psnfa_pkg::OP_GRANT || cmd.op == psnfa_pkg::OP_REJECT) |-> item_stall)
		else $error("An item was taken while a burst was in progress.");
`endif

endmodule

/* rtl/psnfa_ctrl.sv */
// Controller of the next-fit slot allocator.
// Sequences item intake, grants and the closing result; uses psnfa_pkg.
module psnfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [1:0]       item_mode,
	output logic             item_stall,
	input  psnfa_pkg::stat_t stat,
	output psnfa_pkg::cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	assign item_stall = !((state_q == ST_IDLE) && stat.out_free);

	always_comb begin
		cmd.op  = psnfa_pkg::OP_NONE;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && stat.out_free) begin
					if ((item_mode == psnfa_pkg::MODE_EMIT) && !stat.burst_zero) begin
						cmd.op  = psnfa_pkg::OP_LOAD;
						state_d = ST_EMIT;
					end else begin
						cmd.op = psnfa_pkg::OP_STATUS;
					end
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					if (stat.found) begin
						cmd.op = psnfa_pkg::OP_GRANT;
						if (stat.remaining_one) begin
							state_d = ST_IDLE;
						end
					end else begin
						cmd.op  = psnfa_pkg::OP_REJECT;
						state_d = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/psnfa_datapath.sv */
// Datapath of the next-fit slot allocator.
// Holds the alive bits, pointer, counters and output register; uses psnfa_pkg.
module psnfa_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  psnfa_pkg::item_t   item,
	input  psnfa_pkg::cmd_t    cmd,
	output psnfa_pkg::stat_t   stat,
	output psnfa_pkg::result_t result,
	output logic               result_valid,
	input  logic               result_stall
);

	logic [psnfa_pkg::SLOTS-1:0]   alive_q, alive_d;
	logic [psnfa_pkg::SLOT_W-1:0]  next_q, next_d;
	logic [psnfa_pkg::TOTAL_W-1:0] total_q, total_d;
	logic [psnfa_pkg::FRAME_W-1:0] frame_q, frame_d;
	logic [psnfa_pkg::LIVE_W-1:0]  live_q, live_d;
	logic [psnfa_pkg::BURST_W-1:0] remain_q, remain_d;
	logic                          res_valid_q;
	psnfa_pkg::result_t            res_q, res_d;
	logic                          load_res;

	logic [2*psnfa_pkg::SLOTS-1:0] rot_wide;
	logic [psnfa_pkg::SLOTS-1:0]   rot;
	logic [psnfa_pkg::SLOT_W-1:0]  off;
	logic [psnfa_pkg::SLOT_W-1:0]  grant_idx;
	logic [psnfa_pkg::BURST_W-1:0] burst_clamped;
	logic [psnfa_pkg::FRAME_W-1:0] frame_inc;
	logic [psnfa_pkg::TOTAL_W:0]   total_sum;
	logic [psnfa_pkg::TOTAL_W-1:0] total_sat;

	assign rot_wide = {alive_q, alive_q} >> next_q;
	assign rot      = rot_wide[psnfa_pkg::SLOTS-1:0];

	always_comb begin
		off = '0;
		for (int i = psnfa_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!rot[i]) begin
				off = psnfa_pkg::SLOT_W'(i);
			end
		end
	end

	assign grant_idx     = next_q + off;
	assign burst_clamped = (item.burst_count > psnfa_pkg::BURST_W'(psnfa_pkg::MAX_BURST))
		? psnfa_pkg::BURST_W'(psnfa_pkg::MAX_BURST) : item.burst_count;
	assign frame_inc     = (frame_q == '1) ? frame_q : frame_q + psnfa_pkg::FRAME_W'(1);
	assign total_sum     = {1'b0, total_q} + (psnfa_pkg::TOTAL_W + 1)'(remain_q);
	assign total_sat     = total_sum[psnfa_pkg::TOTAL_W] ? '1
		: total_sum[psnfa_pkg::TOTAL_W-1:0];

	assign stat.out_free      = !res_valid_q || !result_stall;
	assign stat.found         = !(&alive_q);
	assign stat.remaining_one = (remain_q == psnfa_pkg::BURST_W'(1));
	assign stat.burst_zero    = (item.burst_count == '0);

	always_comb begin
		alive_d  = alive_q;
		next_d   = next_q;
		total_d  = total_q;
		frame_d  = frame_q;
		live_d   = live_q;
		remain_d = remain_q;
		load_res = 1'b0;
		res_d    = '0;
		unique case (cmd.op)
			psnfa_pkg::OP_STATUS: begin
				load_res   = 1'b1;
				res_d.last = 1'b1;
				unique case (item.mode)
					psnfa_pkg::MODE_RELEASE: begin
						if (alive_q[item.release_index]) begin
							alive_d[item.release_index] = 1'b0;
							live_d = live_q - psnfa_pkg::LIVE_W'(1);
						end
					end
					psnfa_pkg::MODE_CLEAR: begin
						alive_d = '0;
						next_d  = '0;
						frame_d = '0;
						live_d  = '0;
					end
					psnfa_pkg::MODE_FRAME: begin
						frame_d = '0;
					end
					psnfa_pkg::MODE_EMIT: begin
					end
				endcase
			end
			psnfa_pkg::OP_LOAD: begin
				remain_d = burst_clamped;
			end
			psnfa_pkg::OP_GRANT: begin
				alive_d[grant_idx] = 1'b1;
				next_d             = grant_idx + psnfa_pkg::SLOT_W'(1);
				frame_d            = frame_inc;
				live_d             = live_q + psnfa_pkg::LIVE_W'(1);
				remain_d           = remain_q - psnfa_pkg::BURST_W'(1);
				load_res           = 1'b1;
				res_d.slot_index   = grant_idx;
				res_d.granted      = 1'b1;
				res_d.last         = stat.remaining_one;
			end
			psnfa_pkg::OP_REJECT: begin
				total_d            = total_sat;
				load_res           = 1'b1;
				res_d.rejected_now = remain_q;
				res_d.last         = 1'b1;
			end
			default: begin
			end
		endcase
		res_d.emitted_in_frame = frame_d;
		res_d.rejected_sum     = total_d;
		res_d.live_count       = live_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q     <= '0;
			next_q      <= '0;
			total_q     <= '0;
			frame_q     <= '0;
			live_q      <= '0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			alive_q  <= alive_d;
			next_q   <= next_d;
			total_q  <= total_d;
			frame_q  <= frame_d;
			live_q   <= live_d;
			remain_q <= remain_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

/* test/slot_grant_checker.sv */
// Checker for the next-fit slot allocator: watches both channels, predicts each result
// from its own copy of the pool and compares every result transfer field by field.
// Depends on psnfa_pkg.
module slot_grant_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  psnfa_pkg::item_t   item,
	input  logic               item_valid,
	input  logic               item_stall,
	input  psnfa_pkg::result_t result,
	input  logic               result_valid,
	input  logic               result_stall,
	output int                 owed,
	output int                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [psnfa_pkg::SLOTS-1:0]   alive;
	logic [psnfa_pkg::SLOT_W-1:0]  pointer;
	logic [psnfa_pkg::TOTAL_W-1:0] refused_total;
	logic [psnfa_pkg::FRAME_W-1:0] frame_count;
	psnfa_pkg::result_t            owed_results[$];

	initial begin
		fail_count = 0;
		owed = 0;
	end

	task automatic push_result(input logic [psnfa_pkg::SLOT_W-1:0] slot, input logic granted,
			input logic [psnfa_pkg::BURST_W-1:0] refused, input logic last);
		psnfa_pkg::result_t r;
		r.slot_index       = slot;
		r.granted          = granted;
		r.rejected_now     = refused;
		r.emitted_in_frame = frame_count;
		r.rejected_sum     = refused_total;
		r.live_count       = psnfa_pkg::LIVE_W'($countones(alive));
		r.last             = last;
		owed_results.insert(owed_results.size(), r);
	endtask

	task automatic allot_slots(input psnfa_pkg::item_t it);
		int req;
		int idx;
		int off;
		bit found;
		logic [psnfa_pkg::BURST_W-1:0] refused;
		case (it.mode)
			psnfa_pkg::MODE_EMIT: begin
				req = (it.burst_count > psnfa_pkg::MAX_BURST) ? psnfa_pkg::MAX_BURST
					: int'(it.burst_count);
				if (req == 0)
					push_result('0, 1'b0, '0, 1'b1);
				for (int i = 0; i < req; i++) begin
					found = 1'b0;
					idx = 0;
					for (off = 0; off < psnfa_pkg::SLOTS && !found; off++) begin
						idx = (int'(pointer) + off) % psnfa_pkg::SLOTS;
						if (!alive[idx[psnfa_pkg::SLOT_W-1:0]])
							found = 1'b1;
					end
					if (!found) begin
						refused = psnfa_pkg::BURST_W'(req - i);
						if (refused_total > 32'hFFFF_FFFF - psnfa_pkg::TOTAL_W'(refused))
							refused_total = '1;
						else
							refused_total = refused_total + psnfa_pkg::TOTAL_W'(refused);
						push_result('0, 1'b0, refused, 1'b1);
						break;
					end
					alive[idx[psnfa_pkg::SLOT_W-1:0]] = 1'b1;
					pointer = psnfa_pkg::SLOT_W'((idx + 1) % psnfa_pkg::SLOTS);
					if (frame_count != '1)
						frame_count = frame_count + psnfa_pkg::FRAME_W'(1);
					push_result(psnfa_pkg::SLOT_W'(idx), 1'b1, '0, (i + 1 == req));
				end
			end
			psnfa_pkg::MODE_RELEASE: begin
				alive[it.release_index] = 1'b0;
				push_result('0, 1'b0, '0, 1'b1);
			end
			psnfa_pkg::MODE_CLEAR: begin
				alive = '0;
				pointer = '0;
				frame_count = '0;
				push_result('0, 1'b0, '0, 1'b1);
			end
			default: begin
				frame_count = '0;
				push_result('0, 1'b0, '0, 1'b1);
			end
		endcase
	endtask

	task automatic log_fault(input string why, input psnfa_pkg::result_t exp,
			input psnfa_pkg::result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("slot_grant_checker: %s", why);
			$display("  expected slot %0d granted %0d rejected %0d frame %0d total %0d live %0d last %0d",
				exp.slot_index, exp.granted, exp.rejected_now, exp.emitted_in_frame,
				exp.rejected_sum, exp.live_count, exp.last);
			$display("  got      slot %0d granted %0d rejected %0d frame %0d total %0d live %0d last %0d",
				got.slot_index, got.granted, got.rejected_now, got.emitted_in_frame,
				got.rejected_sum, got.live_count, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		psnfa_pkg::result_t exp;
		if (!arst_n) begin
			alive = '0;
			pointer = '0;
			refused_total = '0;
			frame_count = '0;
			owed_results.delete();
		end else begin
			if (item_valid && !item_stall)
				allot_slots(item);
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					log_fault("unexpected result", '0, result);
				end else begin
					exp = owed_results.pop_front();
					if (result.slot_index !== exp.slot_index
							|| result.granted !== exp.granted
							|| result.rejected_now !== exp.rejected_now
							|| result.emitted_in_frame !== exp.emitted_in_frame
							|| result.rejected_sum !== exp.rejected_sum
							|| result.live_count !== exp.live_count
							|| result.last !== exp.last)
						log_fault("mismatch", exp, result);
				end
			end
		end
		owed = owed_results.size();
	end

endmodule

/* test/tb_top.sv */
// Top of the allocator testbench: clock, reset, item stimulus and random result stalls.
// Depends on psnfa_pkg, particle_slot_next_fit_allocator and slot_grant_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	psnfa_pkg::item_t   item = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	psnfa_pkg::result_t result;
	logic               result_valid;
	logic               result_stall = 1'b0;
	int                 owed;
	int                 fail_count;
	bit                 steady = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	particle_slot_next_fit_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	slot_grant_checker grant_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.owed         (owed),
		.fail_count   (fail_count)
	);

	function automatic int idle_cycles();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send(input logic [1:0] mode, input int count, input int index);
		psnfa_pkg::item_t it;
		int gap;
		it.mode = mode;
		it.burst_count = count[psnfa_pkg::BURST_W-1:0];
		it.release_index = index[psnfa_pkg::SLOT_W-1:0];
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		gap = idle_cycles();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic int burst_size();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(0, 6);
		if (r < 95)
			return $urandom_range(7, 20);
		return $urandom_range(21, 127);
	endfunction

	initial begin
		int run;
		forever begin
			repeat ($urandom_range(1, 12)) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end
			run = idle_cycles();
			repeat (run) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
		end
	end

	initial begin
		int r;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send(psnfa_pkg::MODE_EMIT, 0, 9);
		send(psnfa_pkg::MODE_EMIT, 1, 0);
		send(psnfa_pkg::MODE_EMIT, 16, 15);
		send(psnfa_pkg::MODE_EMIT, 5, 0);
		send(psnfa_pkg::MODE_RELEASE, 0, 15);
		send(psnfa_pkg::MODE_RELEASE, 127, 15);
		send(psnfa_pkg::MODE_RELEASE, 0, 0);
		send(psnfa_pkg::MODE_EMIT, 3, 6);
		send(psnfa_pkg::MODE_FRAME, 127, 15);
		send(psnfa_pkg::MODE_EMIT, 127, 0);
		send(psnfa_pkg::MODE_CLEAR, 42, 3);
		send(psnfa_pkg::MODE_EMIT, 64, 12);
		send(psnfa_pkg::MODE_RELEASE, 64, 7);
		send(psnfa_pkg::MODE_EMIT, 2, 0);
		send(psnfa_pkg::MODE_FRAME, 0, 0);
		send(psnfa_pkg::MODE_CLEAR, 0, 0);
		send(psnfa_pkg::MODE_EMIT, 100, 15);
		send(psnfa_pkg::MODE_RELEASE, 1, 4);
		send(psnfa_pkg::MODE_EMIT, 65, 0);

		for (int n = 0; n < 101; n++) begin
			if (n % 20 == 0)
				steady = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (r < 45)
				send(psnfa_pkg::MODE_EMIT, burst_size(), $urandom_range(15));
			else if (r < 78)
				send(psnfa_pkg::MODE_RELEASE, $urandom_range(127), $urandom_range(15));
			else if (r < 88)
				send(psnfa_pkg::MODE_CLEAR, $urandom_range(127), $urandom_range(15));
			else
				send(psnfa_pkg::MODE_FRAME, $urandom_range(127), $urandom_range(15));
		end
		steady = 1'b0;

		@(negedge clk);
		item_valid <= 1'b0;
		while (owed != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* files.f */
rtl/psnfa_pkg.sv
rtl/psnfa_ctrl.sv
rtl/psnfa_datapath.sv
rtl/particle_slot_next_fit_allocator.sv
test/slot_grant_checker.sv
test/tb_top.sv
